@@ rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg : shared types and constants of the C source token scanner
// Transaction structs, byte role and token kind codes, character classes.
// ----------------------------------------------------------------------------
package cst_pkg;

    // Default widths of the line counter and the depth counters
    localparam int LINE_BITS_DEF  = 24;
    localparam int DEPTH_BITS_DEF = 16;

    // Width of the reported line number
    localparam int TOKEN_LINE_W = 24;

    // Byte role codes
    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_FIRST = 2'd1;
    localparam logic [1:0] ROLE_LATER = 2'd2;

    // Token kind codes
    localparam logic [1:0] KIND_IDENT   = 2'd0;
    localparam logic [1:0] KIND_NUMBER  = 2'd1;
    localparam logic [1:0] KIND_DIRECT  = 2'd2;
    localparam logic [1:0] KIND_INCFILE = 2'd3;

    // Include keyword matcher
    localparam logic [3:0] INC_LEN    = 4'd7;
    localparam logic [3:0] MATCH_FAIL = 4'd15;

    // Characters of interest
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Input transaction
    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [7:0]              echo_byte;
        logic [1:0]              byte_role;
        logic [1:0]              token_kind;
        logic [TOKEN_LINE_W-1:0] token_line;
        logic                    is_definition;
        logic                    token_closed;
    } t_out_item;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_gap(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // Letters of the include keyword
    function automatic logic [7:0] inc_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h69;   // i
            3'd1: ch = 8'h6E;   // n
            3'd2: ch = 8'h63;   // c
            3'd3: ch = 8'h6C;   // l
            3'd4: ch = 8'h75;   // u
            3'd5: ch = 8'h64;   // d
            3'd6: ch = 8'h65;   // e
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/cst_lexer.sv @@
// ----------------------------------------------------------------------------
// cst_lexer : scanner state and per-byte step logic
// Holds the scan mode, line and depth counters; computes one result per byte.
// ----------------------------------------------------------------------------
module cst_lexer #(
    parameter int LINE_BITS  = cst_pkg::LINE_BITS_DEF,
    parameter int DEPTH_BITS = cst_pkg::DEPTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_emit_numbers,
    input  cst_pkg::t_in_item i_item,
    output cst_pkg::t_out_item o_result
);

    typedef enum logic [19:0] {
        M_NORMAL      = 20'h00001,
        M_IDENT       = 20'h00002,
        M_NUM_ZERO    = 20'h00004,
        M_NUM_BODY    = 20'h00008,
        M_NUMQ_ZERO   = 20'h00010,
        M_NUMQ_BODY   = 20'h00020,
        M_DIR_GAP     = 20'h00040,
        M_DIR_NAME    = 20'h00080,
        M_SLASH       = 20'h00100,
        M_LINE_CMT    = 20'h00200,
        M_BLOCK       = 20'h00400,
        M_BLOCK_STAR  = 20'h00800,
        M_CHAR        = 20'h01000,
        M_CHAR_ESC    = 20'h02000,
        M_STR         = 20'h04000,
        M_STR_ESC     = 20'h08000,
        M_INC_A_GAP   = 20'h10000,
        M_INC_A_IN    = 20'h20000,
        M_INC_Q_START = 20'h40000,
        M_INC_Q_IN    = 20'h80000
    } t_mode;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_HIGH = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_LOW  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [LINE_BITS-1:0]         LINE_LIMIT = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]         LINE_ONE   = {{(LINE_BITS-1){1'b0}}, 1'b1};

    t_mode                        r_mode, n_mode;
    logic [LINE_BITS-1:0]         r_line, n_line;
    logic signed [DEPTH_BITS-1:0] r_brace, n_brace;
    logic signed [DEPTH_BITS-1:0] r_paren, n_paren;
    logic                         r_at_start, n_at_start;
    logic                         r_inc_pend, n_inc_pend;
    logic [3:0]                   r_match, n_match;

    logic [7:0]                   c;
    logic [1:0]                   role;
    logic [1:0]                   kind;
    logic                         closed;
    logic                         do_norm;
    logic [LINE_BITS+cst_pkg::TOKEN_LINE_W-1:0] line_ext;

    assign c        = i_item.source_byte;
    assign line_ext = {{cst_pkg::TOKEN_LINE_W{1'b0}}, r_line};

    // Step the scanner over one byte
    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_brace    = r_brace;
        n_paren    = r_paren;
        n_at_start = r_at_start;
        n_inc_pend = r_inc_pend;
        n_match    = r_match;
        role       = cst_pkg::ROLE_NONE;
        kind       = cst_pkg::KIND_IDENT;
        do_norm    = 1'b0;
        closed     = (r_mode == M_IDENT) || (r_mode == M_NUM_ZERO) ||
                     (r_mode == M_NUM_BODY) || (r_mode == M_DIR_NAME) ||
                     (r_mode == M_INC_A_IN) || (r_mode == M_INC_Q_IN);

        if (i_item.end_of_input) begin
            // restart line count and mode, keep depths
            n_mode     = M_NORMAL;
            n_line     = LINE_ONE;
            n_at_start = 1'b1;
            n_inc_pend = 1'b0;
            n_match    = 4'd0;
        end else begin
            // mode specific handling
            case (r_mode)
                M_IDENT: begin
                    if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c) ||
                        c == cst_pkg::CH_UNDER) begin
                        role = cst_pkg::ROLE_LATER;
                        kind = cst_pkg::KIND_IDENT;
                    end else begin
                        do_norm = 1'b1;
                    end
                end
                M_NUM_ZERO, M_NUM_BODY, M_NUMQ_ZERO, M_NUMQ_BODY: begin
                    if (cst_pkg::is_hex(c) ||
                        (((r_mode == M_NUM_ZERO) || (r_mode == M_NUMQ_ZERO)) &&
                         ((c == cst_pkg::CH_LOWER_X) || (c == cst_pkg::CH_UPPER_X)))) begin
                        if ((r_mode == M_NUM_ZERO) || (r_mode == M_NUM_BODY)) begin
                            n_mode = M_NUM_BODY;
                            role   = cst_pkg::ROLE_LATER;
                            kind   = cst_pkg::KIND_NUMBER;
                        end else begin
                            n_mode = M_NUMQ_BODY;
                        end
                    end else begin
                        do_norm = 1'b1;
                    end
                end
                M_DIR_GAP: begin
                    if (cst_pkg::is_gap(c)) begin
                        n_mode = M_DIR_GAP;
                    end else if (cst_pkg::is_alpha(c)) begin
                        n_mode  = M_DIR_NAME;
                        role    = cst_pkg::ROLE_FIRST;
                        kind    = cst_pkg::KIND_DIRECT;
                        n_match = (c == cst_pkg::inc_char(3'd0)) ? 4'd1 : cst_pkg::MATCH_FAIL;
                    end else begin
                        do_norm = 1'b1;
                    end
                end
                M_DIR_NAME: begin
                    if (cst_pkg::is_alpha(c)) begin
                        role = cst_pkg::ROLE_LATER;
                        kind = cst_pkg::KIND_DIRECT;
                        if ((r_match < cst_pkg::INC_LEN) &&
                            (c == cst_pkg::inc_char(r_match[2:0]))) begin
                            n_match = r_match + 4'd1;
                        end else begin
                            n_match = cst_pkg::MATCH_FAIL;
                        end
                    end else begin
                        if (r_match == cst_pkg::INC_LEN) begin
                            n_inc_pend = 1'b1;
                        end
                        n_match = 4'd0;
                        do_norm = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == cst_pkg::CH_SLASH) begin
                        n_mode = M_LINE_CMT;
                    end else if (c == cst_pkg::CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        do_norm = 1'b1;
                    end
                end
                M_LINE_CMT: begin
                    if (c == cst_pkg::CH_NL) begin
                        do_norm = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (c == cst_pkg::CH_STAR) begin
                        n_mode = M_BLOCK_STAR;
                    end
                end
                M_BLOCK_STAR: begin
                    if (c == cst_pkg::CH_SLASH) begin
                        n_mode = M_NORMAL;
                    end else if (c != cst_pkg::CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_CHAR: begin
                    if (c == cst_pkg::CH_SQUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_BSLASH) begin
                        n_mode = M_CHAR_ESC;
                    end
                end
                M_CHAR_ESC: begin
                    n_mode = M_CHAR;
                end
                M_STR: begin
                    if (c == cst_pkg::CH_DQUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_BSLASH) begin
                        n_mode = M_STR_ESC;
                    end
                end
                M_STR_ESC: begin
                    n_mode = M_STR;
                end
                M_INC_A_GAP: begin
                    if (cst_pkg::is_gap(c)) begin
                        n_mode = M_INC_A_GAP;
                    end else if (c == cst_pkg::CH_GT) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_NL) begin
                        do_norm = 1'b1;
                    end else begin
                        n_mode = M_INC_A_IN;
                        role   = cst_pkg::ROLE_FIRST;
                        kind   = cst_pkg::KIND_INCFILE;
                    end
                end
                M_INC_A_IN: begin
                    if (c == cst_pkg::CH_GT) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_NL) begin
                        do_norm = 1'b1;
                    end else begin
                        role = cst_pkg::ROLE_LATER;
                        kind = cst_pkg::KIND_INCFILE;
                    end
                end
                M_INC_Q_START: begin
                    if (c == cst_pkg::CH_DQUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_NL) begin
                        do_norm = 1'b1;
                    end else begin
                        n_mode = M_INC_Q_IN;
                        role   = cst_pkg::ROLE_FIRST;
                        kind   = cst_pkg::KIND_INCFILE;
                    end
                end
                M_INC_Q_IN: begin
                    if (c == cst_pkg::CH_DQUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (c == cst_pkg::CH_NL) begin
                        do_norm = 1'b1;
                    end else begin
                        role = cst_pkg::ROLE_LATER;
                        kind = cst_pkg::KIND_INCFILE;
                    end
                end
                default: begin
                    do_norm = 1'b1;
                end
            endcase

            // normal scanning, also after a byte that leaves a token or slash
            if (do_norm) begin
                n_mode = M_NORMAL;
                if ((c == cst_pkg::CH_SPACE) || (c == cst_pkg::CH_TAB) ||
                    (c == cst_pkg::CH_NL)) begin
                    n_mode = M_NORMAL;
                end else if (c == cst_pkg::CH_HASH) begin
                    if (n_at_start) begin
                        n_mode = M_DIR_GAP;
                    end
                    n_at_start = 1'b0;
                end else begin
                    n_at_start = 1'b0;
                    if (c == cst_pkg::CH_LBRACE) begin
                        if (n_brace != DEPTH_HIGH) n_brace = n_brace + 1'b1;
                    end else if (c == cst_pkg::CH_RBRACE) begin
                        if (n_brace != DEPTH_LOW) n_brace = n_brace - 1'b1;
                    end else if (c == cst_pkg::CH_LPAREN) begin
                        if (n_paren != DEPTH_HIGH) n_paren = n_paren + 1'b1;
                    end else if (c == cst_pkg::CH_RPAREN) begin
                        if (n_paren != DEPTH_LOW) n_paren = n_paren - 1'b1;
                    end else if (cst_pkg::is_alpha(c) || (c == cst_pkg::CH_UNDER)) begin
                        n_mode = M_IDENT;
                        role   = cst_pkg::ROLE_FIRST;
                        kind   = cst_pkg::KIND_IDENT;
                    end else if (cst_pkg::is_digit(c)) begin
                        if (i_emit_numbers) begin
                            n_mode = (c == cst_pkg::CH_ZERO) ? M_NUM_ZERO : M_NUM_BODY;
                            role   = cst_pkg::ROLE_FIRST;
                            kind   = cst_pkg::KIND_NUMBER;
                        end else begin
                            n_mode = (c == cst_pkg::CH_ZERO) ? M_NUMQ_ZERO : M_NUMQ_BODY;
                        end
                    end else if (c == cst_pkg::CH_SQUOTE) begin
                        n_mode = M_CHAR;
                    end else if (c == cst_pkg::CH_DQUOTE) begin
                        if (n_inc_pend) begin
                            n_inc_pend = 1'b0;
                            n_mode     = M_INC_Q_START;
                        end else begin
                            n_mode = M_STR;
                        end
                    end else if (c == cst_pkg::CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (c == cst_pkg::CH_LT) begin
                        if (n_inc_pend && (n_brace == '0) && (n_paren == '0)) begin
                            n_inc_pend = 1'b0;
                            n_mode     = M_INC_A_GAP;
                        end
                    end
                end
            end

            if (role == cst_pkg::ROLE_LATER) begin
                closed = 1'b0;
            end

            // count the line on every newline
            if (c == cst_pkg::CH_NL) begin
                if (r_line != LINE_LIMIT) n_line = r_line + 1'b1;
                n_at_start = 1'b1;
                n_inc_pend = 1'b0;
            end
        end

        o_result.echo_byte     = i_item.end_of_input ? 8'd0 : c;
        o_result.byte_role     = role;
        o_result.token_kind    = kind;
        o_result.token_line    = line_ext[cst_pkg::TOKEN_LINE_W-1:0];
        o_result.is_definition = (n_brace == '0) && (n_paren == '0);
        o_result.token_closed  = closed;
    end

    // Advance the state when a byte moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_NORMAL;
            r_line     <= LINE_ONE;
            r_brace    <= '0;
            r_paren    <= '0;
            r_at_start <= 1'b1;
            r_inc_pend <= 1'b0;
            r_match    <= 4'd0;
        end else if (i_adv) begin
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_brace    <= n_brace;
            r_paren    <= n_paren;
            r_at_start <= n_at_start;
            r_inc_pend <= n_inc_pend;
            r_match    <= n_match;
        end
    end

endmodule

@@ rtl/c_source_token_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// c_source_token_scanner_unit : C source token scanner, top level
// Input register, scanner step and result register with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one source byte
//   or an end-of-input marker per transaction. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one result per input, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   emit_numbers bit; it is always ready. The user must write it only while
//   idle; the block itself does not enforce this. Path: a byte accepted into
//   the input register is stepped through the scanner into the result
//   register when the result slot frees up; its result is offered from there.
//   Throughput: one byte per clock while i_out_ready stays high; the per-byte
//   mode update is a single level of compare and select logic in between.
//   Stall: while the receiver holds i_out_ready low, the result holds, the
//   input register keeps one more byte and o_in_ready drops once both are full.
//   Reset (synchronous, active low): clears both valid flags, sets scan mode
//   to normal, line number to one, depths to zero and emit_numbers to zero.
// ----------------------------------------------------------------------------
module c_source_token_scanner_unit #(
    parameter int LINE_BITS  = cst_pkg::LINE_BITS_DEF,
    parameter int DEPTH_BITS = cst_pkg::DEPTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cst_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cst_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic               r_in_vld;
    cst_pkg::t_in_item  r_in;
    logic               r_out_vld;
    cst_pkg::t_out_item r_out;
    logic               r_emit;
    logic               adv;
    logic               in_acc;
    cst_pkg::t_out_item result;

    // Step when the input register is full and the result slot frees up
    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    cst_lexer #(
        .LINE_BITS  (LINE_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_emit_numbers (r_emit),
        .i_item         (r_in),
        .o_result       (result)
    );

    // Hold the configuration bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_cfg_valid) begin
            r_emit <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

endmodule

@@ rtl/cst_checker.sv @@
// ----------------------------------------------------------------------------
// cst_checker : port level checks of the C source token scanner
// Watches the result channel over time and the coding of result fields.
// ----------------------------------------------------------------------------
module cst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cst_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cst_pkg::t_out_item o_out_data,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_data
);

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Byte role stays within its codes
    a_role_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_role == cst_pkg::ROLE_NONE ||
                         o_out_data.byte_role == cst_pkg::ROLE_FIRST ||
                         o_out_data.byte_role == cst_pkg::ROLE_LATER))
        else $error("illegal byte role");

    // Bytes outside a token carry kind identifier
    a_kind_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.byte_role == cst_pkg::ROLE_NONE) |->
        (o_out_data.token_kind == cst_pkg::KIND_IDENT))
        else $error("token kind set outside a token");

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind c_source_token_scanner_unit cst_checker u_cst_checker (.*);

@@ verif/c_source_token_scanner_unit_chk.sv @@
// ----------------------------------------------------------------------------
// c_source_token_scanner_unit_chk : result checker for the token scanner
// Watches the input, result and configuration channels, predicts the result
// of every accepted source byte with its own scanner state machine, and
// compares each accepted result, field by field, against the oldest
// prediction. Hands the number of outstanding predictions and of failures to
// the testbench top.
// ----------------------------------------------------------------------------
module c_source_token_scanner_unit_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  cst_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  cst_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    import cst_pkg::*;

    localparam int LINE_W  = LINE_BITS_DEF;
    localparam int DEPTH_W = DEPTH_BITS_DEF;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [8*7-1:0]            INCLUDE_WORD = "include";

    // Scan modes of the predictor
    typedef enum logic [4:0] {
        SC_PLAIN, SC_WORD, SC_NUM0, SC_NUMB, SC_QNUM0, SC_QNUMB,
        SC_DIR_GAP, SC_DIR_NAME, SC_SLASH, SC_LINE_CMT, SC_BLOCK, SC_BLOCK_STAR,
        SC_CHAR, SC_CHAR_ESC, SC_STR, SC_STR_ESC, SC_ANGLE_GAP, SC_ANGLE_NAME,
        SC_QUOTE_START, SC_QUOTE_NAME
    } scan_mode_e;

    // Predictor state
    scan_mode_e                 mode;
    logic [LINE_W-1:0]          line_no;
    logic signed [DEPTH_W-1:0]  braces;
    logic signed [DEPTH_W-1:0]  parens;
    logic                       line_start;
    logic                       inc_armed;
    logic [3:0]                 inc_pos;
    logic                       emit_num;
    logic [1:0]                 p_role;
    logic [1:0]                 p_kind;

    t_out_item                  predicted_q[$];
    int                         fail_cnt = 0;

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic hex_ch(input logic [7:0] c);
        return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic [7:0] include_letter(input logic [3:0] pos);
        return INCLUDE_WORD[8*(6-int'(pos)) +: 8];
    endfunction

    function automatic logic token_open(input scan_mode_e m);
        return m == SC_WORD || m == SC_NUM0 || m == SC_NUMB ||
               m == SC_DIR_NAME || m == SC_ANGLE_NAME || m == SC_QUOTE_NAME;
    endfunction

    // Saturating depth counter step
    function automatic logic signed [DEPTH_W-1:0] depth_step(
        input logic signed [DEPTH_W-1:0] d,
        input logic                      up
    );
        if (up) return (d == DEPTH_MAX) ? d : d + 1;
        return (d == DEPTH_MIN) ? d : d - 1;
    endfunction

    // Normal scanning of one byte outside any token or literal
    function automatic void plain_scan(input logic [7:0] c);
        mode = SC_PLAIN;
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return;
        if (c == CH_HASH) begin
            if (line_start) mode = SC_DIR_GAP;
            line_start = 1'b0;
            return;
        end
        line_start = 1'b0;
        if (c == CH_LBRACE) begin
            braces = depth_step(braces, 1'b1);
        end else if (c == CH_RBRACE) begin
            braces = depth_step(braces, 1'b0);
        end else if (c == CH_LPAREN) begin
            parens = depth_step(parens, 1'b1);
        end else if (c == CH_RPAREN) begin
            parens = depth_step(parens, 1'b0);
        end else if (letter_ch(c) || c == CH_UNDER) begin
            mode   = SC_WORD;
            p_role = ROLE_FIRST;
            p_kind = KIND_IDENT;
        end else if (digit_ch(c)) begin
            if (emit_num) begin
                if (c == CH_ZERO) mode = SC_NUM0;
                else mode = SC_NUMB;
                p_role = ROLE_FIRST;
                p_kind = KIND_NUMBER;
            end else begin
                if (c == CH_ZERO) mode = SC_QNUM0;
                else mode = SC_QNUMB;
            end
        end else if (c == CH_SQUOTE) begin
            mode = SC_CHAR;
        end else if (c == CH_DQUOTE) begin
            if (inc_armed) begin
                inc_armed = 1'b0;
                mode      = SC_QUOTE_START;
            end else begin
                mode = SC_STR;
            end
        end else if (c == CH_SLASH) begin
            mode = SC_SLASH;
        end else if (c == CH_LT && inc_armed && braces == 0 && parens == 0) begin
            inc_armed = 1'b0;
            mode      = SC_ANGLE_GAP;
        end
    endfunction

    // Advance the predictor by one input transaction and return its result
    function automatic t_out_item scan_byte(input t_in_item it);
        logic [7:0]        c;
        logic              closed;
        logic              loud;
        logic              zero;
        logic [LINE_W-1:0] here;
        t_out_item         r;
        c      = it.source_byte;
        p_role = ROLE_NONE;
        p_kind = KIND_IDENT;
        closed = token_open(mode);
        here   = line_no;
        r.token_line = TOKEN_LINE_W'(here);

        // End marker: close the token, restart line count and mode
        if (it.end_of_input) begin
            r.echo_byte     = '0;
            r.byte_role     = ROLE_NONE;
            r.token_kind    = KIND_IDENT;
            r.is_definition = (braces == 0) && (parens == 0);
            r.token_closed  = closed;
            mode       = SC_PLAIN;
            line_no    = 1;
            line_start = 1'b1;
            inc_armed  = 1'b0;
            inc_pos    = '0;
            return r;
        end

        case (mode)
            SC_WORD: begin
                if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
                    p_role = ROLE_LATER;
                    p_kind = KIND_IDENT;
                end else begin
                    plain_scan(c);
                end
            end
            SC_NUM0, SC_NUMB, SC_QNUM0, SC_QNUMB: begin
                loud = (mode == SC_NUM0) || (mode == SC_NUMB);
                zero = (mode == SC_NUM0) || (mode == SC_QNUM0);
                if (hex_ch(c) || (zero && (c == CH_LOWER_X || c == CH_UPPER_X))) begin
                    if (loud) begin
                        mode   = SC_NUMB;
                        p_role = ROLE_LATER;
                        p_kind = KIND_NUMBER;
                    end else begin
                        mode = SC_QNUMB;
                    end
                end else begin
                    plain_scan(c);
                end
            end
            SC_DIR_GAP: begin
                if (!blank_ch(c)) begin
                    if (letter_ch(c)) begin
                        mode    = SC_DIR_NAME;
                        p_role  = ROLE_FIRST;
                        p_kind  = KIND_DIRECT;
                        inc_pos = (c == include_letter(4'd0)) ? 4'd1 : MATCH_FAIL;
                    end else begin
                        plain_scan(c);
                    end
                end
            end
            SC_DIR_NAME: begin
                if (letter_ch(c)) begin
                    p_role = ROLE_LATER;
                    p_kind = KIND_DIRECT;
                    if (inc_pos < INC_LEN && c == include_letter(inc_pos)) inc_pos = inc_pos + 1;
                    else inc_pos = MATCH_FAIL;
                end else begin
                    if (inc_pos == INC_LEN) inc_armed = 1'b1;
                    inc_pos = '0;
                    plain_scan(c);
                end
            end
            SC_SLASH: begin
                if (c == CH_SLASH) mode = SC_LINE_CMT;
                else if (c == CH_STAR) mode = SC_BLOCK;
                else plain_scan(c);
            end
            SC_LINE_CMT: begin
                if (c == CH_NL) plain_scan(c);
            end
            SC_BLOCK: begin
                if (c == CH_STAR) mode = SC_BLOCK_STAR;
            end
            SC_BLOCK_STAR: begin
                if (c == CH_SLASH) mode = SC_PLAIN;
                else if (c != CH_STAR) mode = SC_BLOCK;
            end
            SC_CHAR: begin
                if (c == CH_SQUOTE) mode = SC_PLAIN;
                else if (c == CH_BSLASH) mode = SC_CHAR_ESC;
            end
            SC_CHAR_ESC: mode = SC_CHAR;
            SC_STR: begin
                if (c == CH_DQUOTE) mode = SC_PLAIN;
                else if (c == CH_BSLASH) mode = SC_STR_ESC;
            end
            SC_STR_ESC: mode = SC_STR;
            SC_ANGLE_GAP: begin
                if (!blank_ch(c)) begin
                    if (c == CH_GT) begin
                        mode = SC_PLAIN;
                    end else if (c == CH_NL) begin
                        plain_scan(c);
                    end else begin
                        mode   = SC_ANGLE_NAME;
                        p_role = ROLE_FIRST;
                        p_kind = KIND_INCFILE;
                    end
                end
            end
            SC_ANGLE_NAME: begin
                if (c == CH_GT) begin
                    mode = SC_PLAIN;
                end else if (c == CH_NL) begin
                    plain_scan(c);
                end else begin
                    p_role = ROLE_LATER;
                    p_kind = KIND_INCFILE;
                end
            end
            SC_QUOTE_START: begin
                if (c == CH_DQUOTE) begin
                    mode = SC_PLAIN;
                end else if (c == CH_NL) begin
                    plain_scan(c);
                end else begin
                    mode   = SC_QUOTE_NAME;
                    p_role = ROLE_FIRST;
                    p_kind = KIND_INCFILE;
                end
            end
            SC_QUOTE_NAME: begin
                if (c == CH_DQUOTE) begin
                    mode = SC_PLAIN;
                end else if (c == CH_NL) begin
                    plain_scan(c);
                end else begin
                    p_role = ROLE_LATER;
                    p_kind = KIND_INCFILE;
                end
            end
            default: plain_scan(c);
        endcase

        if (p_role == ROLE_LATER) closed = 1'b0;

        // Every newline counts a line, in whatever mode it arrives
        if (c == CH_NL) begin
            if (line_no != '1) line_no = line_no + 1;
            line_start = 1'b1;
            inc_armed  = 1'b0;
        end

        r.echo_byte     = c;
        r.byte_role     = p_role;
        r.token_kind    = p_kind;
        r.is_definition = (braces == 0) && (parens == 0);
        r.token_closed  = closed;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Compare results, track configuration, predict new transactions
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            mode       = SC_PLAIN;
            line_no    = 1;
            braces     = '0;
            parens     = '0;
            line_start = 1'b1;
            inc_armed  = 1'b0;
            inc_pos    = '0;
            emit_num   = 1'b0;
            predicted_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    fail_cnt++;
                end else begin
                    want = predicted_q.pop_front();
                    check_field("echo_byte", want.echo_byte, i_out_data.echo_byte);
                    check_field("byte_role", want.byte_role, i_out_data.byte_role);
                    check_field("token_kind", want.token_kind, i_out_data.token_kind);
                    check_field("token_line", want.token_line, i_out_data.token_line);
                    check_field("is_definition", want.is_definition,
                                i_out_data.is_definition);
                    check_field("token_closed", want.token_closed,
                                i_out_data.token_closed);
                end
            end
            if (i_cfg_valid && i_cfg_ready) emit_num = i_cfg_data;
            if (i_in_valid && i_in_ready) predicted_q.push_back(scan_byte(i_in_data));
        end
        o_pending    = predicted_q.size();
        o_fail_count = fail_cnt;
    end

endmodule

@@ verif/c_source_token_scanner_unit_tb.sv @@
// ----------------------------------------------------------------------------
// c_source_token_scanner_unit_tb : testbench top for the token scanner
// Drives C-like source text into the scanner: a short directed sequence, then
// random fragments (identifiers, numbers, comments, literals, directives and
// include names, punctuation, noise bytes, end markers) under varying sender
// and receiver idling and a long receiver hold-off. The checker module
// predicts and compares; this top makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module c_source_token_scanner_unit_tb;

    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 200_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cst_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    cst_pkg::t_out_item out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    int                 pending;
    int                 fail_count;
    int                 cycle_count   = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic               hold_req      = 1'b0;
    int                 brace_bal     = 0;
    int                 paren_bal     = 0;
    cst_pkg::t_in_item  src_q[$];

    string     word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string     alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string     hex_set   = "0123456789abcdefABCDEF";
    string     punct_set = ";,=+-*<>&|!?.[]~%^:";
    string     path_set  = "abcxyz./_019-";
    string     gap_set   = " \t\v\f\r";

    c_source_token_scanner_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    c_source_token_scanner_unit_chk u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random ready, or a long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        cst_pkg::t_in_item it;
        it.source_byte  = c;
        it.end_of_input = 1'b0;
        src_q.push_back(it);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    // Body byte of a comment or literal, never a newline or either stop byte
    function automatic logic [7:0] text_byte(input logic [7:0] x0, input logic [7:0] x1);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
            else c = 8'($urandom_range(32, 126));
        end while (c == x0 || c == x1 || c == cst_pkg::CH_NL);
        return c;
    endfunction

    // Queue one random fragment of C-like source
    function automatic void build_fragment();
        int                pick;
        int                k;
        int                n;
        cst_pkg::t_in_item it;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            // identifier
            put_byte(pick_from(word_set));
            repeat ($urandom_range(0, 6)) put_byte(pick_from(alnum_set));
        end else if (pick < 28) begin
            // number: decimal, hex after 0x, or digit followed by letters, digits or underscores
            k = $urandom_range(0, 2);
            if (k == 0) begin
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(48, 57)));
            end else if (k == 1) begin
                put_byte(cst_pkg::CH_ZERO);
                put_byte($urandom_range(0, 1) ? cst_pkg::CH_LOWER_X : cst_pkg::CH_UPPER_X);
                repeat ($urandom_range(0, 4)) put_byte(pick_from(hex_set));
            end else begin
                put_byte(8'($urandom_range(48, 57)));
                repeat ($urandom_range(1, 3)) put_byte(pick_from(alnum_set));
            end
        end else if (pick < 38) begin
            repeat ($urandom_range(1, 3)) put_byte(pick_from(gap_set));
        end else if (pick < 46) begin
            put_byte(cst_pkg::CH_NL);
        end else if (pick < 51) begin
            // line comment
            put_byte(cst_pkg::CH_SLASH);
            put_byte(cst_pkg::CH_SLASH);
            repeat ($urandom_range(0, 8)) put_byte(text_byte(cst_pkg::CH_NL, cst_pkg::CH_NL));
            put_byte(cst_pkg::CH_NL);
        end else if (pick < 58) begin
            // block comment, stars and newlines inside
            put_byte(cst_pkg::CH_SLASH);
            put_byte(cst_pkg::CH_STAR);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 5);
                if (k == 0) put_byte(cst_pkg::CH_STAR);
                else if (k == 1) put_byte(cst_pkg::CH_NL);
                else put_byte(text_byte(cst_pkg::CH_NL, cst_pkg::CH_NL));
            end
            repeat ($urandom_range(1, 2)) put_byte(cst_pkg::CH_STAR);
            put_byte(cst_pkg::CH_SLASH);
        end else if (pick < 65) begin
            // string with escapes, continued and raw newlines
            put_byte(cst_pkg::CH_DQUOTE);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 7);
                if (k == 0) begin
                    put_byte(cst_pkg::CH_BSLASH);
                    put_byte($urandom_range(0, 1) ? cst_pkg::CH_NL :
                             8'($urandom_range(0, 255)));
                end else if (k == 1) begin
                    put_byte(cst_pkg::CH_NL);
                end else begin
                    put_byte(text_byte(cst_pkg::CH_DQUOTE, cst_pkg::CH_BSLASH));
                end
            end
            put_byte(cst_pkg::CH_DQUOTE);
        end else if (pick < 70) begin
            // character literal
            put_byte(cst_pkg::CH_SQUOTE);
            if ($urandom_range(0, 2) == 0) begin
                put_byte(cst_pkg::CH_BSLASH);
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                put_byte(text_byte(cst_pkg::CH_SQUOTE, cst_pkg::CH_BSLASH));
            end
            put_byte(cst_pkg::CH_SQUOTE);
        end else if (pick < 80) begin
            // directive at line start, include forms in half of them
            put_byte(cst_pkg::CH_NL);
            if ($urandom_range(0, 3) == 0) put_byte(cst_pkg::CH_SPACE);
            put_byte(cst_pkg::CH_HASH);
            repeat ($urandom_range(0, 2)) put_byte(pick_from(" \t"));
            k = $urandom_range(0, 7);
            if (k < 4) begin
                put_text("include");
            end else if (k == 4) begin
                case ($urandom_range(0, 4))
                    0: put_text("includ");
                    1: put_text("includes");
                    2: put_text("inclxde");
                    3: put_text("define");
                    default: put_text("Include");
                endcase
            end else if (k == 5) begin
                repeat ($urandom_range(1, 6)) put_byte(pick_from(word_set));
            end else if (k == 6) begin
                put_byte(pick_from("1(;<_"));
            end
            if (k <= 5) begin
                repeat ($urandom_range(0, 2)) put_byte(cst_pkg::CH_SPACE);
                n = $urandom_range(0, 6);
                case ($urandom_range(0, 4))
                    0: begin
                        put_byte(cst_pkg::CH_LT);
                        repeat ($urandom_range(0, 2)) put_byte(cst_pkg::CH_SPACE);
                        repeat (n) put_byte(pick_from(path_set));
                        put_byte(cst_pkg::CH_GT);
                    end
                    1: begin
                        put_byte(cst_pkg::CH_DQUOTE);
                        repeat (n) put_byte(pick_from(path_set));
                        put_byte(cst_pkg::CH_DQUOTE);
                    end
                    2: begin
                        put_byte(cst_pkg::CH_LT);
                        repeat (n) put_byte(pick_from(path_set));
                    end
                    3: begin
                        put_byte(cst_pkg::CH_DQUOTE);
                        repeat (n) put_byte(pick_from(path_set));
                    end
                    default: repeat (n) put_byte(pick_from(alnum_set));
                endcase
            end
            put_byte(cst_pkg::CH_NL);
        end else if (pick < 88) begin
            // punctuation, keep the nesting loosely balanced
            k = $urandom_range(0, 2);
            if (k == 0) begin
                if (brace_bal > 0 && (brace_bal > 3 || $urandom_range(0, 1))) begin
                    put_byte(cst_pkg::CH_RBRACE);
                    brace_bal--;
                end else begin
                    put_byte(cst_pkg::CH_LBRACE);
                    brace_bal++;
                end
            end else if (k == 1) begin
                if (paren_bal > 0 && (paren_bal > 3 || $urandom_range(0, 1))) begin
                    put_byte(cst_pkg::CH_RPAREN);
                    paren_bal--;
                end else begin
                    put_byte(cst_pkg::CH_LPAREN);
                    paren_bal++;
                end
            end else begin
                put_byte(pick_from(punct_set));
            end
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        end else if (pick < 96) begin
            // lone slash followed by something that opens no comment
            put_byte(cst_pkg::CH_SLASH);
            put_byte(pick_from("a_=1 ("));
        end else if (pick < 98) begin
            // hash in the middle of a line
            put_byte(pick_from(word_set));
            put_byte(cst_pkg::CH_HASH);
            put_byte(pick_from(" a1"));
        end else begin
            it.source_byte  = 8'($urandom_range(0, 255));
            it.end_of_input = 1'b1;
            src_q.push_back(it);
        end
    endfunction

    // Offer one transaction and hold it until accepted; returns at a falling edge
    task automatic push_item(input cst_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (src_q.size() != 0) push_item(src_q.pop_front());
    endtask

    task automatic random_phase(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_fragment();
            sent += src_q.size();
            send_queued();
        end
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_emit(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        cst_pkg::t_in_item it;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty quoted include, hash without name, literal across a
        // line, lone slash, byte extremes, end marker
        write_emit(1'b1);
        put_text("#include\"\"\n# 1\n'\n'a/b");
        put_byte(8'hFF);
        put_byte(8'h00);
        it.source_byte  = 8'hFF;
        it.end_of_input = 1'b1;
        src_q.push_back(it);
        send_queued();
        drain_results();

        // Slow sender, busy receiver, then a long hold-off to fill the block
        write_emit(1'b0);
        send_idle_pct = 16;
        recv_idle_pct = 66;
        random_phase(260);
        hold_req = 1'b1;
        random_phase(60);
        drain_results();

        // Idle sender, fast receiver
        write_emit(1'b1);
        send_idle_pct = 66;
        recv_idle_pct = 16;
        random_phase(260);
        drain_results();

        // Back to back
        write_emit(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120);
        drain_results();
        write_emit(1'b1);
        random_phase(120);

        // Restart the mode and finish with a short definition
        it.source_byte  = 8'h00;
        it.end_of_input = 1'b1;
        push_item(it);
        put_text("main(){x}\n");
        send_queued();

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
